// File: rtl/text_line_statistics_unit_assert.svh
// Assertion macros for the text line statistics unit.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef TEXT_LINE_STATISTICS_UNIT_ASSERT_SVH
`define TEXT_LINE_STATISTICS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define TLS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TLS_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define TLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/tls_pkg.sv
// Shared constants for the text line statistics unit.
// No dependencies; used by text_line_statistics_unit.
`timescale 1ns / 1ps

package tls_pkg;

   // Default counter widths.
   localparam int COUNT_BITS_DEFAULT = 48;
   localparam int WIDTH_BITS_DEFAULT = 32;

   // The file count is always this wide.
   localparam int FILES_BITS = 32;

   // Request codes on req_type.
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_EOF  = 1'b1;

   // Line terminator.
   localparam logic [7:0] NEWLINE_CODE = 8'h0A;

endpackage

// File: rtl/text_line_statistics_unit.sv
// Text line statistics unit: per-file and running byte and line counts.
// Depends on tls_pkg and text_line_statistics_unit_assert.svh.
`timescale 1ns / 1ps
`include "text_line_statistics_unit_assert.svh"

// Usage
// The request channel carries one beat per text byte (req_type = REQ_BYTE) or
// an end-of-file marker (req_type = REQ_EOF). Byte beats produce no response.
// Each end-of-file beat produces one response beat holding the statistics of
// the file just ended and the running totals over all ended files; the
// per-file counters then restart at zero.
// Throughput is one request beat per cycle while req_stall is low. Each byte
// updates the counters in the cycle it is accepted; the response to an end of
// file is registered and presented from the response register.
// A second response register catches a result when the receiver stalls, so
// requests keep flowing; req_stall rises only while both response registers
// are full and falls once the receiver takes a beat.
// A synchronous reset clears all counters and totals, sets the smallest file
// size to all ones and empties both response registers. All counters
// saturate at the top of their widths.
module text_line_statistics_unit #(
   parameter int COUNT_BITS = tls_pkg::COUNT_BITS_DEFAULT,
   parameter int WIDTH_BITS = tls_pkg::WIDTH_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_type,
   input  logic [7:0]                     req_data_byte,
   // Response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [COUNT_BITS-1:0]          rsp_file_bytes,
   output logic [COUNT_BITS-1:0]          rsp_file_lines,
   output logic [COUNT_BITS-1:0]          rsp_file_nonempty_lines,
   output logic [WIDTH_BITS-1:0]          rsp_file_max_line_width,
   output logic [tls_pkg::FILES_BITS-1:0] rsp_total_files,
   output logic [COUNT_BITS-1:0]          rsp_total_bytes,
   output logic [COUNT_BITS-1:0]          rsp_total_lines,
   output logic [COUNT_BITS-1:0]          rsp_total_nonempty_lines,
   output logic [COUNT_BITS-1:0]          rsp_most_file_lines,
   output logic [COUNT_BITS-1:0]          rsp_least_file_bytes,
   output logic [COUNT_BITS-1:0]          rsp_most_file_bytes
);

   localparam int FB = tls_pkg::FILES_BITS;

   // One response beat as it is held in the output registers. Empty-line
   // counts are kept and turned into non-empty counts at the ports.
   typedef struct packed {
      logic [COUNT_BITS-1:0] file_bytes;
      logic [COUNT_BITS-1:0] file_lines;
      logic [COUNT_BITS-1:0] file_empty;
      logic [WIDTH_BITS-1:0] file_max;
      logic [FB-1:0]         files;
      logic [COUNT_BITS-1:0] sum_bytes;
      logic [COUNT_BITS-1:0] sum_lines;
      logic [COUNT_BITS-1:0] sum_empty;
      logic [COUNT_BITS-1:0] peak_lines;
      logic [COUNT_BITS-1:0] low_size;
      logic [COUNT_BITS-1:0] high_size;
   } result_type;

   // Per-file state. Line count and widest line already include an open,
   // unterminated line, so an end of file needs no extra fold.
   logic [COUNT_BITS-1:0] cur_bytes_ff, cur_bytes_in;
   logic [COUNT_BITS-1:0] cur_lines_ff, cur_lines_in;
   logic [COUNT_BITS-1:0] cur_empty_ff, cur_empty_in;
   logic [WIDTH_BITS-1:0] cur_line_len_ff, cur_line_len_in;
   logic [WIDTH_BITS-1:0] cur_max_len_ff, cur_max_len_in;

   // Running totals.
   logic [FB-1:0]         sum_files_ff, sum_files_in;
   logic [COUNT_BITS-1:0] sum_bytes_ff, sum_bytes_in;
   logic [COUNT_BITS-1:0] sum_lines_ff, sum_lines_in;
   logic [COUNT_BITS-1:0] sum_empty_ff, sum_empty_in;
   logic [COUNT_BITS-1:0] peak_lines_ff, peak_lines_in;
   logic [COUNT_BITS-1:0] low_size_ff, low_size_in;
   logic [COUNT_BITS-1:0] high_size_ff, high_size_in;

   // Response and skid registers.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   result_type result;

   logic accept, byte_beat, eof_beat, is_newline, line_open;
   logic out_free;
   logic [WIDTH_BITS-1:0] len_inc;
   logic [COUNT_BITS:0]   bytes_sum, lines_sum, empty_sum;

   // Handshake decode.
   assign req_stall  = skid_valid_ff;
   assign accept     = req_valid && !req_stall;
   assign byte_beat  = accept && (req_type == tls_pkg::REQ_BYTE);
   assign eof_beat   = accept && (req_type == tls_pkg::REQ_EOF);
   assign is_newline = (req_data_byte == tls_pkg::NEWLINE_CODE);
   assign line_open  = (cur_line_len_ff != '0);

   // Saturating increment of the current line length.
   assign len_inc = (cur_line_len_ff == '1) ? cur_line_len_ff
                                            : cur_line_len_ff + WIDTH_BITS'(1);

   // Per-file counter updates. A byte at the start of a line opens a line,
   // whether it is a newline (empty line) or not.
   always_comb begin
      cur_bytes_in    = cur_bytes_ff;
      cur_lines_in    = cur_lines_ff;
      cur_empty_in    = cur_empty_ff;
      cur_line_len_in = cur_line_len_ff;
      cur_max_len_in  = cur_max_len_ff;
      if (eof_beat) begin
         cur_bytes_in    = '0;
         cur_lines_in    = '0;
         cur_empty_in    = '0;
         cur_line_len_in = '0;
         cur_max_len_in  = '0;
      end else if (byte_beat) begin
         if (cur_bytes_ff != '1) begin
            cur_bytes_in = cur_bytes_ff + COUNT_BITS'(1);
         end
         if (!line_open && (cur_lines_ff != '1)) begin
            cur_lines_in = cur_lines_ff + COUNT_BITS'(1);
         end
         if (is_newline) begin
            cur_line_len_in = '0;
            if (!line_open && (cur_empty_ff != '1)) begin
               cur_empty_in = cur_empty_ff + COUNT_BITS'(1);
            end
         end else begin
            cur_line_len_in = len_inc;
            if (cur_line_len_ff >= cur_max_len_ff) begin
               cur_max_len_in = len_inc;
            end
         end
      end
   end

   // Running totals, updated at each end of file.
   assign bytes_sum = {1'b0, sum_bytes_ff} + {1'b0, cur_bytes_ff};
   assign lines_sum = {1'b0, sum_lines_ff} + {1'b0, cur_lines_ff};
   assign empty_sum = {1'b0, sum_empty_ff} + {1'b0, cur_empty_ff};

   always_comb begin
      sum_files_in  = sum_files_ff;
      sum_bytes_in  = sum_bytes_ff;
      sum_lines_in  = sum_lines_ff;
      sum_empty_in  = sum_empty_ff;
      peak_lines_in = peak_lines_ff;
      low_size_in   = low_size_ff;
      high_size_in  = high_size_ff;
      if (eof_beat) begin
         if (sum_files_ff != '1) begin
            sum_files_in = sum_files_ff + FB'(1);
         end
         sum_bytes_in = bytes_sum[COUNT_BITS] ? '1 : bytes_sum[COUNT_BITS-1:0];
         sum_lines_in = lines_sum[COUNT_BITS] ? '1 : lines_sum[COUNT_BITS-1:0];
         sum_empty_in = empty_sum[COUNT_BITS] ? '1 : empty_sum[COUNT_BITS-1:0];
         if (cur_lines_ff > peak_lines_ff) begin
            peak_lines_in = cur_lines_ff;
         end
         if (cur_bytes_ff < low_size_ff) begin
            low_size_in = cur_bytes_ff;
         end
         if (cur_bytes_ff > high_size_ff) begin
            high_size_in = cur_bytes_ff;
         end
      end
   end

   // Result of the end-of-file beat in flight.
   always_comb begin
      result.file_bytes = cur_bytes_ff;
      result.file_lines = cur_lines_ff;
      result.file_empty = cur_empty_ff;
      result.file_max   = cur_max_len_ff;
      result.files      = sum_files_in;
      result.sum_bytes  = sum_bytes_in;
      result.sum_lines  = sum_lines_in;
      result.sum_empty  = sum_empty_in;
      result.peak_lines = peak_lines_in;
      result.low_size   = low_size_in;
      result.high_size  = high_size_in;
   end

   // Response register with a skid stage behind it.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (eof_beat) begin
            out_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (eof_beat) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   // Control and statistics registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_bytes_ff    <= '0;
         cur_lines_ff    <= '0;
         cur_empty_ff    <= '0;
         cur_line_len_ff <= '0;
         cur_max_len_ff  <= '0;
         sum_files_ff    <= '0;
         sum_bytes_ff    <= '0;
         sum_lines_ff    <= '0;
         sum_empty_ff    <= '0;
         peak_lines_ff   <= '0;
         low_size_ff     <= '1;
         high_size_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         cur_bytes_ff    <= cur_bytes_in;
         cur_lines_ff    <= cur_lines_in;
         cur_empty_ff    <= cur_empty_in;
         cur_line_len_ff <= cur_line_len_in;
         cur_max_len_ff  <= cur_max_len_in;
         sum_files_ff    <= sum_files_in;
         sum_bytes_ff    <= sum_bytes_in;
         sum_lines_ff    <= sum_lines_in;
         sum_empty_ff    <= sum_empty_in;
         peak_lines_ff   <= peak_lines_in;
         low_size_ff     <= low_size_in;
         high_size_ff    <= high_size_in;
         rsp_valid_ff    <= rsp_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   // Response payload registers need no reset.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // Output ports. Non-empty counts are lines minus empty lines, floored at zero.
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_file_bytes          = out_ff.file_bytes;
   assign rsp_file_lines          = out_ff.file_lines;
   assign rsp_file_nonempty_lines = (out_ff.file_lines > out_ff.file_empty)
                                  ? out_ff.file_lines - out_ff.file_empty : '0;
   assign rsp_file_max_line_width = out_ff.file_max;
   assign rsp_total_files         = out_ff.files;
   assign rsp_total_bytes         = out_ff.sum_bytes;
   assign rsp_total_lines         = out_ff.sum_lines;
   assign rsp_total_nonempty_lines = (out_ff.sum_lines > out_ff.sum_empty)
                                   ? out_ff.sum_lines - out_ff.sum_empty : '0;
   assign rsp_most_file_lines     = out_ff.peak_lines;
   assign rsp_least_file_bytes    = out_ff.low_size;
   assign rsp_most_file_bytes     = out_ff.high_size;

   // The skid register is only ever filled behind a full response register.
   `TLS_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff, "skid full while response register empty")

   // An end of file that meets a stalled response must land in the skid register.
   `TLS_ASSERT_NEXT(a_eof_to_skid, clock, reset, eof_beat && rsp_valid_ff && rsp_stall, skid_valid_ff, "stalled end-of-file result was dropped")

   // Per-file counters restart after every end of file.
   `TLS_ASSERT_NEXT(a_file_cleared, clock, reset, eof_beat, (cur_bytes_ff == '0) && (cur_lines_ff == '0) && (cur_line_len_ff == '0), "per-file counters not cleared")

   // The widest line always covers the open line.
   `TLS_ASSERT_SAME(a_max_covers_open, clock, reset, line_open, cur_max_len_ff >= cur_line_len_ff, "open line wider than recorded maximum")

   // Once a file has ended, the smallest size cannot exceed the largest.
   `TLS_ASSERT_SAME(a_size_order, clock, reset, sum_files_ff != '0, low_size_ff <= high_size_ff, "smallest file size above largest")

endmodule
